// File: design/sdik_pkg.sv
// Shared types, constants and the arctangent table for the swerve drive
// inverse kinematics block. No dependencies.
`default_nettype none

package sdik_pkg;

  // datapath widths: CORDIC x/y and Q20 angle accumulator
  localparam int unsigned XW = 32;
  localparam int unsigned ZW = 24;
  localparam int unsigned WW = 29;          // wheel vector in Q12 mm/s
  localparam int unsigned MAX_STEPS = 24;

  localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;

  // output scaling
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [15:0] CDEG_MUL     = 16'd45837;
  localparam logic [14:0] ANG_MAX      = 15'd25736;
  localparam logic [14:0] CDEG_MAX     = 15'd18000;
  localparam logic [16:0] SPEED_MAX    = 17'h1FFFF;
  localparam logic [15:0] RPM_MAX      = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_BASE_X = 2'd0;
  localparam logic [1:0] CFG_HALF_BASE_Y = 2'd1;
  localparam logic [1:0] CFG_RPM_GAIN    = 2'd2;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_ISSUE,
    ST_WAIT
  } sdik_state_e;

  // one wheel vector travelling down the CORDIC chain
  typedef struct packed {
    logic [1:0]           wheel;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } sdik_vec_t;

  // one finished wheel word
  typedef struct packed {
    logic [1:0]         wheel;
    logic signed [15:0] angle;
    logic signed [15:0] cdeg;
    logic [16:0]        speed;
    logic [15:0]        rpm;
    logic               held;
    logic               accepted;
    logic               last;
  } sdik_res_t;

  // atan(2^-i) in Q20 radians
  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned i);
    case (i)
      0:  return 24'sd823550;
      1:  return 24'sd486170;
      2:  return 24'sd256879;
      3:  return 24'sd130396;
      4:  return 24'sd65451;
      5:  return 24'sd32757;
      6:  return 24'sd16383;
      7:  return 24'sd8192;
      8:  return 24'sd4096;
      9:  return 24'sd2048;
      10: return 24'sd1024;
      11: return 24'sd512;
      12: return 24'sd256;
      13: return 24'sd128;
      14: return 24'sd64;
      15: return 24'sd32;
      16: return 24'sd16;
      17: return 24'sd8;
      18: return 24'sd4;
      19: return 24'sd2;
      20: return 24'sd1;
      default: return 24'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: design/swerve_drive_inverse_kinematics.sv
// Top level of the four-wheel swerve drive inverse kinematics block.
// Depends on sdik_pkg, sdik_cell, sdik_post and sdik_fifo.
`default_nettype none

// Takes one body velocity command word and returns four wheel words
// (front-left, front-right, rear-left, rear-right), or a single rejected word
// when cmd_valid is low. One command is in work at a time. A valid command
// first forms w*X and w*Y, then feeds its four wheel vectors one per cycle
// into a chain of CORDIC_STEPS iteration cells (at most 24) followed by a
// four-stage scaling pipeline. It issues only once earlier words have left
// the output queue, and the block takes the next command once the last wheel
// word is in the output queue. No clearing pass is needed after reset.
// Configuration is a plain write port: index 0 half_base_x, 1 half_base_y,
// 2 rpm_gain.
module swerve_drive_inverse_kinematics
  import sdik_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  // command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // vel_x, vel_y, yaw_rate
  input  wire logic [0:0]  s_axis_tuser,   // cmd_valid
  // wheel stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // steer_angle, steer_centideg,
                                           // wheel_speed, motor_rpm, zero pad
  output logic [3:0]       m_axis_tuser,   // wheel_num, angle_held, accepted
  output logic             m_axis_tlast    // last_result
);

  localparam int unsigned NSteps = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  // configuration registers
  logic [11:0] half_x_q, half_y_q;
  logic [19:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_x_q <= '0;
      half_y_q <= '0;
      gain_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_BASE_X: half_x_q <= cfg_data_i[11:0];
        CFG_HALF_BASE_Y: half_y_q <= cfg_data_i[11:0];
        CFG_RPM_GAIN:    gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  sdik_state_e state_q, state_d;
  logic [1:0]  wheel_q, wheel_d;
  logic        in_acc, rej_wr, issue;
  logic        fifo_empty, fifo_full, post_vld;
  sdik_res_t   post_res;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    wheel_d       = wheel_q;
    s_axis_tready = 1'b0;
    rej_wr        = 1'b0;
    issue         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = !fifo_full;
        if (in_acc) begin
          if (s_axis_tuser[0]) begin
            state_d = ST_PROD;
          end else begin
            rej_wr = 1'b1;
          end
        end
      end
      ST_PROD: begin
        wheel_d = 2'd0;
        // all four wheel words must fit in the queue
        if (fifo_empty) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        issue   = 1'b1;
        wheel_d = wheel_q + 2'd1;
        if (wheel_q == 2'd3) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (post_vld && post_res.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wheel_q <= '0;
    end else begin
      state_q <= state_d;
      wheel_q <= wheel_d;
    end
  end

  // command capture and yaw products
  logic signed [15:0]   vx_q, vy_q, w_q;
  logic signed [WW-1:0] pbx_q, pby_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vx_q <= s_axis_tdata[15:0];
      vy_q <= s_axis_tdata[31:16];
      w_q  <= s_axis_tdata[47:32];
    end
    if (state_q == ST_PROD) begin
      pbx_q <= WW'(w_q * $signed({1'b0, half_x_q}));
      pby_q <= WW'(w_q * $signed({1'b0, half_y_q}));
    end
  end

  // wheel vector: Vx = vx - w*Yi, Vy = vy + w*Xi, Q12 mm/s
  logic signed [WW-1:0] vx12, vy12, wx_d, wy_d, wx_q, wy_q;
  logic                 iss_vld_q;
  logic [1:0]           iss_wheel_q;

  always_comb begin
    vx12 = $signed({vx_q[15], vx_q, 12'd0});
    vy12 = $signed({vy_q[15], vy_q, 12'd0});
    wx_d = wheel_q[0] ? (vx12 + pby_q) : (vx12 - pby_q);
    wy_d = wheel_q[1] ? (vy12 - pbx_q) : (vy12 + pbx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_vld_q <= 1'b0;
    end else begin
      iss_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_wheel_q <= wheel_q;
    wx_q        <= wx_d;
    wy_q        <= wy_d;
  end

  // pre-rotation by pi into the right half plane
  logic signed [XW-1:0] wx_ext, wy_ext;
  sdik_vec_t            pre_d;
  sdik_vec_t            chain_vec [NSteps+1];
  logic [NSteps:0]      chain_vld;
  sdik_vec_t            pre_q;
  logic                 pre_vld_q;

  always_comb begin
    wx_ext      = $signed({{(XW-WW){wx_q[WW-1]}}, wx_q});
    wy_ext      = $signed({{(XW-WW){wy_q[WW-1]}}, wy_q});
    pre_d.wheel = iss_wheel_q;
    pre_d.zero  = (wx_q == '0) && (wy_q == '0);
    if (wx_q[WW-1]) begin
      pre_d.x = -wx_ext;
      pre_d.y = -wy_ext;
      pre_d.z = wy_q[WW-1] ? -PI_Q20 : PI_Q20;
    end else begin
      pre_d.x = wx_ext;
      pre_d.y = wy_ext;
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else begin
      pre_vld_q <= iss_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
  end

  assign chain_vec[0] = pre_q;
  assign chain_vld[0] = pre_vld_q;

  // CORDIC iteration chain
  for (genvar g = 0; g < NSteps; g++) begin : g_cell
    sdik_cell #(
      .Stage(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (chain_vld[g]),
      .vec_i (chain_vec[g]),
      .vld_o (chain_vld[g+1]),
      .vec_o (chain_vec[g+1])
    );
  end

  sdik_post u_post (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .gain_i(gain_q),
    .vld_i (chain_vld[NSteps]),
    .vec_i (chain_vec[NSteps]),
    .vld_o (post_vld),
    .res_o (post_res)
  );

  // result queue: rejected words only arrive while the pipeline is empty
  sdik_res_t fifo_wdata, fifo_rdata;
  logic      fifo_rd;

  always_comb begin
    if (post_vld) begin
      fifo_wdata = post_res;
    end else begin
      fifo_wdata      = '0;
      fifo_wdata.last = 1'b1;
    end
  end

  assign fifo_rd = m_axis_tvalid && m_axis_tready;

  sdik_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (post_vld || rej_wr),
    .wdata_i(fifo_wdata),
    .rd_i   (fifo_rd),
    .rdata_o(fifo_rdata),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  // output word
  assign m_axis_tvalid = !fifo_empty;
  assign m_axis_tdata  = {7'd0, fifo_rdata.rpm, fifo_rdata.speed,
                          fifo_rdata.cdeg, fifo_rdata.angle};
  assign m_axis_tuser  = {fifo_rdata.accepted, fifo_rdata.held, fifo_rdata.wheel};
  assign m_axis_tlast  = fifo_rdata.last;

endmodule

`default_nettype wire

// File: design/sdik_cell.sv
// One vectoring CORDIC iteration with its output register.
// Depends on sdik_pkg.
`default_nettype none

module sdik_cell
  import sdik_pkg::*;
#(
  parameter int unsigned Stage = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      vld_i,
  input  wire sdik_vec_t vec_i,
  output logic           vld_o,
  output sdik_vec_t      vec_o
);

  localparam logic signed [ZW-1:0] Atan = atan_q20(Stage);

  logic signed [XW-1:0] x_in, y_in, xs, ys;
  logic signed [ZW-1:0] z_in;
  sdik_vec_t            vec_d, vec_q;
  logic                 vld_q;

  // rotate towards the x axis, direction from the sign of y
  always_comb begin
    x_in  = vec_i.x;
    y_in  = vec_i.y;
    z_in  = vec_i.z;
    xs    = x_in >>> Stage;
    ys    = y_in >>> Stage;
    vec_d = vec_i;
    if (!y_in[XW-1]) begin
      vec_d.x = x_in + ys;
      vec_d.y = y_in - xs;
      vec_d.z = z_in + Atan;
    end else begin
      vec_d.x = x_in - ys;
      vec_d.y = y_in + xs;
      vec_d.z = z_in - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vld_o = vld_q;
  assign vec_o = vec_q;

endmodule

`default_nettype wire

// File: design/sdik_post.sv
// Output scaling: angle rounding, centidegrees, speed, rpm and the
// per-wheel held angle store. Depends on sdik_pkg.
`default_nettype none

module sdik_post
  import sdik_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [19:0] gain_i,
  input  wire logic        vld_i,
  input  wire sdik_vec_t   vec_i,
  output logic             vld_o,
  output sdik_res_t        res_o
);

  // stage 1: angle magnitude and raw speed product
  logic signed [ZW-1:0] z;
  logic [ZW-1:0]        zabs;
  logic [16:0]          angm_full;
  logic [14:0]          angm_d;
  logic [30:0]          mag;
  logic signed [XW-1:0] x;

  logic        v1_q, zero1_q, neg1_q;
  logic [1:0]  wh1_q;
  logic [14:0] angm1_q;
  logic [46:0] sp1_q;

  always_comb begin
    z         = vec_i.z;
    x         = vec_i.x;
    zabs      = z[ZW-1] ? ZW'(-z) : ZW'(z);
    angm_full = 17'((25'(zabs) + 25'd64) >> 7);
    angm_d    = (angm_full > 17'(ANG_MAX)) ? ANG_MAX : angm_full[14:0];
    mag       = x[XW-1] ? 31'd0 : x[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    wh1_q   <= vec_i.wheel;
    zero1_q <= vec_i.zero;
    neg1_q  <= z[ZW-1];
    angm1_q <= angm_d;
    sp1_q   <= 47'(mag) * 47'(INV_GAIN_Q16);
  end

  // stage 2: centidegree product, speed rounding and saturation
  logic [47:0] sp_sum;
  logic [19:0] spd_full;
  logic [16:0] spd_d;

  logic        v2_q, zero2_q, neg2_q;
  logic [1:0]  wh2_q;
  logic [14:0] angm2_q;
  logic [30:0] cd2_q;
  logic [16:0] spd2_q;

  always_comb begin
    sp_sum   = 48'(sp1_q) + (48'd1 << 27);
    spd_full = 20'(sp_sum >> 28);
    spd_d    = (spd_full > 20'(SPEED_MAX)) ? SPEED_MAX : spd_full[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wh2_q   <= wh1_q;
    zero2_q <= zero1_q;
    neg2_q  <= neg1_q;
    angm2_q <= angm1_q;
    cd2_q   <= 31'(angm1_q) * 31'(CDEG_MUL);
    spd2_q  <= spd_d;
  end

  // stage 3: signs, held angle substitution, rpm product
  logic signed [15:0] held_ang_q [4];
  logic signed [15:0] held_cdeg_q [4];
  logic [31:0]        cd_sum;
  logic [15:0]        cdm_full;
  logic [14:0]        cdm;
  logic signed [15:0] ang_new, cdeg_new;

  logic               v3_q;
  sdik_res_t          res3_q;
  logic [36:0]        rp3_q;

  always_comb begin
    cd_sum   = 32'(cd2_q) + 32'd32768;
    cdm_full = 16'(cd_sum >> 16);
    cdm      = (cdm_full > 16'(CDEG_MAX)) ? CDEG_MAX : cdm_full[14:0];
    ang_new  = neg2_q ? -$signed({1'b0, angm2_q}) : $signed({1'b0, angm2_q});
    cdeg_new = neg2_q ? -$signed({1'b0, cdm}) : $signed({1'b0, cdm});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        held_ang_q[i]  <= '0;
        held_cdeg_q[i] <= '0;
      end
    end else begin
      v3_q <= v2_q;
      if (v2_q && !zero2_q) begin
        held_ang_q[wh2_q]  <= ang_new;
        held_cdeg_q[wh2_q] <= cdeg_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res3_q.wheel    <= wh2_q;
    res3_q.angle    <= zero2_q ? held_ang_q[wh2_q] : ang_new;
    res3_q.cdeg     <= zero2_q ? held_cdeg_q[wh2_q] : cdeg_new;
    res3_q.speed    <= spd2_q;
    res3_q.rpm      <= '0;
    res3_q.held     <= zero2_q;
    res3_q.accepted <= 1'b1;
    res3_q.last     <= (wh2_q == 2'd3);
    rp3_q           <= 37'(spd2_q) * 37'(gain_i);
  end

  // stage 4: rpm rounding and saturation
  logic [37:0] rp_sum;
  logic [21:0] rpm_full;
  logic        v4_q;
  sdik_res_t   res4_d, res4_q;

  always_comb begin
    rp_sum     = 38'(rp3_q) + 38'd32768;
    rpm_full   = 22'(rp_sum >> 16);
    res4_d     = res3_q;
    res4_d.rpm = (rpm_full > 22'(RPM_MAX)) ? RPM_MAX : rpm_full[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res4_q <= res4_d;
  end

  assign vld_o = v4_q;
  assign res_o = res4_q;

endmodule

`default_nettype wire

// File: design/sdik_fifo.sv
// Four-entry result queue between the pipeline and the output stream.
// Depends on sdik_pkg.
`default_nettype none

module sdik_fifo
  import sdik_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_i,
  input  wire sdik_res_t wdata_i,
  input  wire logic      rd_i,
  output sdik_res_t      rdata_o,
  output logic           empty_o,
  output logic           full_o
);

  sdik_res_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_AW:0]   cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the swerve drive inverse kinematics block: drives command
// words, predicts the wheel words of each and checks them on the wheel stream.
// Depends on sdik_pkg and swerve_drive_inverse_kinematics.
`default_nettype none

module tb;
  import sdik_pkg::*;

  localparam int STEPS        = 16;
  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = 40;     // idle gap before reconfiguring and at the end of the run

  // scaling used by the wheel predictor
  localparam longint HALF_TURN_Q20 = 3294199;
  localparam longint MAG_SCALE     = 39797;
  localparam longint DEG_SCALE     = 45837;
  localparam longint ANGLE_LIM     = 25736;
  localparam longint CDEG_LIM      = 18000;
  localparam longint SPEED_LIM     = 131071;
  localparam longint RPM_LIM       = 65535;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_HALF_BASE_X;
  logic [19:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // vel_x, vel_y, yaw_rate
  logic [0:0]  s_axis_tuser  = '0;   // cmd_valid
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  wire  [71:0] m_axis_tdata;         // steer_angle, steer_centideg, wheel_speed, motor_rpm, pad
  wire  [3:0]  m_axis_tuser;         // wheel_num, angle_held, accepted
  wire         m_axis_tlast;         // last_result

  swerve_drive_inverse_kinematics #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of the registers and the held angles
  logic [11:0]        base_x = '0;
  logic [11:0]        base_y = '0;
  logic [19:0]        gain   = '0;
  logic signed [15:0] held_ang  [4];
  logic signed [15:0] held_cdeg [4];
  longint atan_tab [24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                            4096, 2048, 1024, 512, 256, 128, 64, 32,
                            16, 8, 4, 2, 1, 0, 0, 0};

  sdik_res_t wheel_words_due [$];
  int        errors   = 0;
  int        cycles   = 0;
  bit        src_idle = 1'b1;
  bit        snk_idle = 1'b1;
  bit        valid_up = 1'b0;
  int        snk_wait = 0;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (errors < 100)
      $display("tb: %s mismatch at cycle %0d: got %0d, expected %0d",
               field, cycles, got, want);
    errors++;
  endtask

  function automatic longint round_sym(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // vectoring rotation: angle in Q20, magnitude still carrying the CORDIC gain
  function automatic void cordic_vector(input longint x0, input longint y0,
                                        output longint z, output longint mag);
    longint x, y, xs, ys;
    x = x0;
    y = y0;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ((STEPS > 24) ? 24 : STEPS); i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_tab[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_tab[i];
      end
    end
    mag = (x < 0) ? 0 : x;
  endfunction

  // expected wheel words of one command, or its single rejected word
  function automatic void predict_wheels(input logic signed [15:0] vx, input logic signed [15:0] vy,
                                         input logic signed [15:0] w, input logic ok);
    sdik_res_t word;
    longint    xi, yi, wx, wy, z, mag, ang, cdeg, spd, rpm;
    word = '0;
    if (!ok) begin
      word.last = 1'b1;
      wheel_words_due.push_back(word);
      return;
    end
    for (int k = 0; k < 4; k++) begin
      xi = (k < 2) ? longint'(base_x) : -longint'(base_x);
      yi = (k % 2 == 1) ? -longint'(base_y) : longint'(base_y);
      wx = longint'(vx) * 4096 - longint'(w) * yi;
      wy = longint'(vy) * 4096 + longint'(w) * xi;
      word          = '0;
      word.wheel    = 2'(k);
      word.accepted = 1'b1;
      word.last     = (k == 3);
      if (wx == 0 && wy == 0) begin
        // zero vector: keep the last steering angle
        word.angle = held_ang[k];
        word.cdeg  = held_cdeg[k];
        word.held  = 1'b1;
      end else begin
        cordic_vector(wx, wy, z, mag);
        ang = round_sym(z, 7);
        if (ang > ANGLE_LIM) ang = ANGLE_LIM;
        if (ang < -ANGLE_LIM) ang = -ANGLE_LIM;
        cdeg = round_sym(ang * DEG_SCALE, 16);
        if (cdeg > CDEG_LIM) cdeg = CDEG_LIM;
        if (cdeg < -CDEG_LIM) cdeg = -CDEG_LIM;
        spd = (mag * MAG_SCALE + (longint'(1) << 27)) >>> 28;
        if (spd > SPEED_LIM) spd = SPEED_LIM;
        rpm = (spd * longint'(gain) + 32768) >>> 16;
        if (rpm > RPM_LIM) rpm = RPM_LIM;
        word.angle   = 16'(ang);
        word.cdeg    = 16'(cdeg);
        word.speed   = 17'(spd);
        word.rpm     = 16'(rpm);
        held_ang[k]  = word.angle;
        held_cdeg[k] = word.cdeg;
      end
      wheel_words_due.push_back(word);
    end
  endfunction

  // output side: random stall after each accepted word
  always @(posedge clk_i) begin : wheel_sink
    int unsigned gap;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        gap = snk_idle ? $urandom_range(7, 0) : 0;
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          snk_wait      <= gap;
        end
      end else if (snk_wait != 0) begin
        snk_wait <= snk_wait - 1;
        if (snk_wait == 1) m_axis_tready <= 1'b1;
      end
    end
  end

  // check each wheel word against the oldest expectation
  always @(posedge clk_i) begin : wheel_check
    sdik_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.angle    = m_axis_tdata[15:0];
      got.cdeg     = m_axis_tdata[31:16];
      got.speed    = m_axis_tdata[48:32];
      got.rpm      = m_axis_tdata[64:49];
      got.wheel    = m_axis_tuser[1:0];
      got.held     = m_axis_tuser[2];
      got.accepted = m_axis_tuser[3];
      got.last     = m_axis_tlast;
      if (wheel_words_due.size() == 0) begin
        report_mismatch("unexpected word, wheel_num", got.wheel, 0);
      end else begin
        want = wheel_words_due.pop_front();
        if (got.wheel !== want.wheel)       report_mismatch("wheel_num", got.wheel, want.wheel);
        if (got.angle !== want.angle)       report_mismatch("steer_angle", got.angle, want.angle);
        if (got.cdeg !== want.cdeg)         report_mismatch("steer_centideg", got.cdeg, want.cdeg);
        if (got.speed !== want.speed)       report_mismatch("wheel_speed", got.speed, want.speed);
        if (got.rpm !== want.rpm)           report_mismatch("motor_rpm", got.rpm, want.rpm);
        if (got.held !== want.held)         report_mismatch("angle_held", got.held, want.held);
        if (got.accepted !== want.accepted) report_mismatch("accepted", got.accepted, want.accepted);
        if (got.last !== want.last)         report_mismatch("last_result", got.last, want.last);
      end
    end
  end

  // one command word, after a random gap
  task automatic send_cmd(input logic signed [15:0] vx, input logic signed [15:0] vy,
                          input logic signed [15:0] w, input logic ok);
    int unsigned gap;
    gap = src_idle ? $urandom_range(7, 0) : 0;
    if (gap != 0) begin
      if (valid_up) s_axis_tvalid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, vy, vx};
    s_axis_tuser  <= ok;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_wheels(vx, vy, w, ok);
  endtask

  // hold the sender until every wheel word has come back
  task automatic wait_results_done();
    if (valid_up) s_axis_tvalid <= 1'b0;
    valid_up = 1'b0;
    do @(posedge clk_i); while (wheel_words_due.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HALF_BASE_X: base_x = val[11:0];
      CFG_HALF_BASE_Y: base_y = val[11:0];
      CFG_RPM_GAIN:    gain   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [11:0] x, input logic [11:0] y, input logic [19:0] g);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(CFG_HALF_BASE_X, {8'd0, x});
    write_reg(CFG_HALF_BASE_Y, {8'd0, y});
    write_reg(CFG_RPM_GAIN, g);
  endtask

  // registers at reset: offsets and gain zero
  task automatic test_reset_state();
    send_cmd(16'sd0, 16'sd0, 16'sd0, 1'b1);        // all wheels zero, held angle 0
    send_cmd(16'sd1000, 16'sd0, 16'sd5000, 1'b1);
    send_cmd(-16'sd1, 16'sd0, 16'sd0, 1'b1);       // negative x on the axis: +pi
    send_cmd(16'sd123, -16'sd456, 16'sd789, 1'b0); // rejected
  endtask

  // largest offsets and gain with extreme commands
  task automatic test_extreme_geometry();
    set_config(12'hFFF, 12'hFFF, 20'hFFFFF);
    send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_cmd(-16'sh8000, -16'sh8000, -16'sh8000, 1'b1);
    send_cmd(16'sh7FFF, -16'sh8000, -16'sh8000, 1'b1);
    send_cmd(-16'sh8000, 16'sd0, 16'sd0, 1'b1);
    send_cmd(-16'sd5, -16'sd1, 16'sd0, 1'b1);       // negative x, negative y: -pi side
    send_cmd(16'sd0, -16'sh8000, 16'sd0, 1'b1);
    send_cmd(-16'sd1, -16'sd1, -16'sd1, 1'b0);      // rejected, all data bits set
    send_cmd(16'sd4095, -16'sd4095, 16'sd4096, 1'b1); // front-left vector zero
    send_cmd(-16'sd4095, -16'sd4095, 16'sd4096, 1'b1); // front-right vector zero
  endtask

  // held angle after a turn, and gain limits
  task automatic test_held_and_gain();
    set_config(12'd300, 12'd200, 20'd0);
    send_cmd(16'sd2500, -16'sd900, 16'sd1234, 1'b1);
    send_cmd(16'sd200, -16'sd300, 16'sd4096, 1'b1);  // front-left held at the new angle
    send_cmd(16'sd200, -16'sd300, 16'sd4096, 1'b1);
    set_config(12'd0, 12'hFFF, 20'd1);
    send_cmd(16'sd0, 16'sd0, -16'sh8000, 1'b1);
    send_cmd(16'sd0, 16'sd0, 16'sd0, 1'b1);          // all held after the turn
    send_cmd(16'sd30000, 16'sd1, 16'sd0, 1'b1);
  endtask

  // random commands over several register settings
  task automatic test_random_commands(input int count);
    logic signed [15:0] vx, vy, w;
    logic               ok;
    int unsigned        kind, k;
    int                 m;
    longint             xi, yi;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        case (n / 100)
          0: set_config(12'($urandom), 12'($urandom), 20'($urandom));
          1: set_config(12'd0, 12'd0, 20'($urandom));
          2: set_config(12'hFFF, 12'hFFF, 20'hFFFFF);
          3: set_config(12'($urandom_range(255, 0)), 12'($urandom_range(255, 0)),
                        20'($urandom_range(200000, 0)));
          default: set_config(12'($urandom), 12'($urandom), 20'($urandom));
        endcase
      end
      if (n % 25 == 0) begin
        src_idle = ($urandom_range(3, 0) != 0);
        snk_idle = ($urandom_range(3, 0) != 0);
      end
      if (n % 37 == 36) wait_results_done();
      kind = $urandom_range(99, 0);
      vx   = 16'($urandom);
      vy   = 16'($urandom);
      w    = 16'($urandom);
      ok   = 1'b1;
      if (kind < 15) begin
        vx = 16'($urandom_range(400, 0) - 200);
        vy = 16'($urandom_range(400, 0) - 200);
        w  = 16'($urandom_range(2000, 0) - 1000);
      end else if (kind < 28) begin
        // one wheel vector cancelled exactly by the yaw term
        m  = int'($urandom_range(14, 0)) - 7;
        k  = $urandom_range(3, 0);
        xi = (k < 2) ? longint'(base_x) : -longint'(base_x);
        yi = (k % 2 == 1) ? -longint'(base_y) : longint'(base_y);
        vx = 16'(m * yi);
        vy = 16'(-m * xi);
        w  = 16'(m * 4096);
      end else if (kind < 38) begin
        ok = 1'b0;
      end else if (kind < 42) begin
        vx = '0;
        vy = '0;
        w  = '0;
      end
      send_cmd(vx, vy, w, ok);
    end
  endtask

  initial begin
    for (int k = 0; k < 4; k++) begin
      held_ang[k]  = '0;
      held_cdeg[k] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_extreme_geometry();
    test_held_and_gain();
    test_random_commands(500);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && wheel_words_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/sdik_pkg.sv
design/sdik_cell.sv
design/sdik_post.sv
design/sdik_fifo.sv
design/swerve_drive_inverse_kinematics.sv
bench/tb.sv
